>>> src/fnv_pkg.sv
// ----------------------------------------------------------------------------
// fnv_pkg: shared constants and types of the FNV key hash engine
// Holds the FNV offset bases and primes, the mode encoding and the init
// value lookup per mode.
// ----------------------------------------------------------------------------
`default_nettype none

package fnv_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned OutW  = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [63:0] FNV64_INIT  = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV64_PRIME = 64'h00000100000001b3;
  localparam logic [31:0] FNV32_INIT  = 32'd2166136261;
  localparam logic [31:0] FNV32_PRIME = 32'd16777619;

  // Primes split as 2^k + small constant, so a multiply is a shift and a
  // narrow constant product.
  localparam int unsigned FNV64_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV64_PRIME_LO    = 9'h1b3;
  localparam int unsigned FNV32_PRIME_SHIFT = 24;
  localparam logic [8:0]  FNV32_PRIME_LO    = 9'h193;

  typedef enum logic [1:0] {
    VAR_FNV1_64   = 2'd0,
    VAR_FNV1A_64T = 2'd1,
    VAR_FNV1_32   = 2'd2,
    VAR_FNV1A_32  = 2'd3
  } variant_t;

  function automatic logic [63:0] init_for(variant_t mode);
    logic [63:0] val;
    unique case (mode)
      VAR_FNV1_64:   val = FNV64_INIT;
      VAR_FNV1A_64T: val = {32'd0, FNV64_INIT[31:0]};
      default:       val = {32'd0, FNV32_INIT};
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> src/fnv_key_hash_engine_top.sv
// ----------------------------------------------------------------------------
// fnv_key_hash_engine_top: streaming FNV-1 / FNV-1a key hash
// A last beat waits in s1 until out_* is free, then its hash is registered there.
// Throughput: one key byte per cycle unless a held last beat stalls the input;
//   the hash updates in one pass of a shift-and-add constant multiply and XOR.
// Reset (rst_n low, synchronous): drops any buffered beat, clears out_valid,
//   selects FNV-1 64 and loads its offset basis into the running hash.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_key_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_variant,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_hash_value
);

  fnv_pkg::variant_t variant_r;
  logic [63:0]       hash_r, hash_nxt, hash_mixed;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_present_r;
  logic              s1_last_r;

  logic              out_valid_r;
  logic [31:0]       out_hash_r;

  logic              out_free;
  logic              s1_move;
  logic              in_take;

  logic [63:0]       mul64;
  logic [31:0]       s_lo, x_lo, mul_t, mul_fnv1_32, mul_fnv1a_32;
  logic [63:0]       byte_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // Mix one byte into the running hash.
  assign byte_ext     = {56'd0, s1_byte_r};
  assign s_lo         = hash_r[31:0];
  assign x_lo         = s_lo ^ {24'd0, s1_byte_r};
  assign mul64        = (hash_r << fnv_pkg::FNV64_PRIME_SHIFT)
                        + (hash_r * 64'(fnv_pkg::FNV64_PRIME_LO));
  assign mul_t        = x_lo * 32'(fnv_pkg::FNV64_PRIME_LO);
  assign mul_fnv1_32  = (s_lo << fnv_pkg::FNV32_PRIME_SHIFT)
                        + (s_lo * 32'(fnv_pkg::FNV32_PRIME_LO));
  assign mul_fnv1a_32 = (x_lo << fnv_pkg::FNV32_PRIME_SHIFT)
                        + (x_lo * 32'(fnv_pkg::FNV32_PRIME_LO));

  always_comb begin
    unique case (variant_r)
      fnv_pkg::VAR_FNV1_64:   hash_mixed = mul64 ^ byte_ext;
      fnv_pkg::VAR_FNV1A_64T: hash_mixed = {32'd0, mul_t};
      fnv_pkg::VAR_FNV1_32:   hash_mixed = {32'd0, mul_fnv1_32 ^ {24'd0, s1_byte_r}};
      default:                hash_mixed = {32'd0, mul_fnv1a_32};
    endcase
  end

  always_comb begin
    hash_nxt = hash_r;
    if (s1_move) begin
      if (s1_last_r) begin
        hash_nxt = fnv_pkg::init_for(variant_r);
      end else if (s1_present_r) begin
        hash_nxt = hash_mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r   <= fnv_pkg::VAR_FNV1_64;
      hash_r      <= fnv_pkg::init_for(fnv_pkg::VAR_FNV1_64);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        // new mode drops any partial key
        variant_r <= fnv_pkg::variant_t'(cfg_variant);
        hash_r    <= fnv_pkg::init_for(fnv_pkg::variant_t'(cfg_variant));
      end else begin
        hash_r <= hash_nxt;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r    <= in_key_byte;
      s1_present_r <= in_byte_present;
      s1_last_r    <= in_last_byte;
    end
    if (s1_move && s1_last_r) begin
      out_hash_r <= s1_present_r ? hash_mixed[31:0] : hash_r[31:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

`ifndef SYNTHESIS
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked last beat");

  a_upper_zero_32: assert property (@(posedge clk) disable iff (!rst_n)
    (variant_r != fnv_pkg::VAR_FNV1_64) |-> (hash_r[63:32] == 32'd0))
    else $error("upper hash bits set in a 32-bit mode");

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result raised without a last beat");

  a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_move && !cfg_we) |=> $stable(hash_r))
    else $error("running hash changed with no beat or config write");
`endif

endmodule

`default_nettype wire

>>> verif/fnv_key_hash_engine_top_tb.sv
// ----------------------------------------------------------------------------
// fnv_key_hash_engine_top_tb: self-checking bench for the streaming FNV hash
// Streams key bytes through all four hash modes and checks every emitted
// hash against an in-bench model of the running FNV state. Covers empty keys,
// idle beats, partial keys dropped by a mode change, random gaps on both
// sides, and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fnv_key_hash_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OFFSET64    = 64'hcbf29ce484222325;
  localparam logic [63:0] PRIME64     = 64'h00000100000001b3;
  localparam logic [31:0] OFFSET32    = 32'h811c9dc5;
  localparam logic [31:0] PRIME32     = 32'h01000193;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1400;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_variant;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_key_byte;
  logic        in_byte_present;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_hash_value;

  fnv_pkg::variant_t model_mode;
  logic [63:0] model_hash;
  logic [31:0] expected_hashes[$];

  bit          no_idle;
  int          hold_left;
  int          stall_left;
  int          errors;
  int          beats_sent;
  int          hashes_seen;
  int          cycle_count;

  fnv_key_hash_engine_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_variant    (cfg_variant),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_byte    (in_key_byte),
    .in_byte_present(in_byte_present),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hashes still pending", cycle_count,
               expected_hashes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] mode_seed(fnv_pkg::variant_t mode);
    case (mode)
      fnv_pkg::VAR_FNV1_64:   return OFFSET64;
      fnv_pkg::VAR_FNV1A_64T: return {32'd0, OFFSET64[31:0]};
      default:                return {32'd0, OFFSET32};
    endcase
  endfunction

  function automatic logic [63:0] fold_byte(fnv_pkg::variant_t mode, logic [63:0] h,
                                            logic [7:0] b);
    logic [31:0] s;
    s = h[31:0];
    case (mode)
      fnv_pkg::VAR_FNV1_64: return (h * PRIME64) ^ {56'd0, b};
      fnv_pkg::VAR_FNV1A_64T: begin
        // 64-bit prime truncated to its low word
        s = (s ^ {24'd0, b}) * PRIME64[31:0];
        return {32'd0, s};
      end
      fnv_pkg::VAR_FNV1_32: begin
        s = (s * PRIME32) ^ {24'd0, b};
        return {32'd0, s};
      end
      default: begin
        s = (s ^ {24'd0, b}) * PRIME32;
        return {32'd0, s};
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key_byte     <= b;
    in_byte_present <= present;
    in_last_byte    <= last;
    do @(posedge clk); while (in_stall);
    if (present) model_hash = fold_byte(model_mode, model_hash, b);
    if (last) begin
      expected_hashes.push_back(model_hash[31:0]);
      model_hash = mode_seed(model_mode);
    end
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_key(input int unsigned len);
    if (len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    for (int unsigned i = 0; i < len; i++) begin
      if (!no_idle && $urandom_range(0, 9) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, i == len - 1);
    end
  endtask

  // Hold the input until every hash is out and the pipe has flushed.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_variant(input fnv_pkg::variant_t mode);
    cfg_we      <= 1'b1;
    cfg_variant <= mode;
    @(negedge clk);
    cfg_we      <= 1'b0;
    model_mode = mode;
    model_hash = mode_seed(mode);
  endtask

  task automatic test_reset_mode();
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_each_mode();
    for (int m = 0; m < 4; m++) begin
      wait_idle();
      write_variant(fnv_pkg::variant_t'(m));
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hc3, 1'b0, 1'b0);
      send_beat(8'h5a, 1'b1, 1'b1);
    end
  endtask

  task automatic test_partial_key_drop();
    wait_idle();
    write_variant(fnv_pkg::VAR_FNV1_32);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    wait_idle();
    write_variant(fnv_pkg::VAR_FNV1A_64T);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h64, 1'b1, 1'b1);
  endtask

  task automatic test_back_pressure();
    wait_idle();
    no_idle = 1'b1;
    @(posedge clk);
    hold_left = 120;
    @(negedge clk);
    repeat (40) send_key($urandom_range(1, 3));
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_keys(input int n_items);
    int start_beats;
    int keys_left;
    int pick;
    start_beats = beats_sent;
    keys_left   = 0;
    while (beats_sent - start_beats < n_items) begin
      if (keys_left == 0) begin
        // leave a partial key behind now and then; the mode write must drop it
        if ($urandom_range(0, 1) == 1)
          repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        wait_idle();
        write_variant(fnv_pkg::variant_t'($urandom_range(0, 3)));
        no_idle   = ($urandom_range(0, 3) == 0);
        keys_left = $urandom_range(15, 45);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)
        repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      else if (pick == 1)
        send_key(0);
      else if (pick == 2)
        send_key($urandom_range(13, 40));
      else
        send_key($urandom_range(1, 12));
      keys_left--;
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : hash_checker
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      hashes_seen++;
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
      if (expected_hashes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected hash beat: got %h", out_hash_value);
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want) begin
          errors++;
          if (errors <= 10)
            $display("hash mismatch: expected %h, got %h", want, out_hash_value);
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_variant     = fnv_pkg::VAR_FNV1_64;
    in_valid        = 1'b0;
    in_key_byte     = 8'h00;
    in_byte_present = 1'b0;
    in_last_byte    = 1'b0;
    no_idle         = 1'b0;
    hold_left       = 0;
    stall_left      = 0;
    errors          = 0;
    beats_sent      = 0;
    hashes_seen     = 0;
    cycle_count     = 0;
    model_mode      = fnv_pkg::VAR_FNV1_64;
    model_hash      = mode_seed(fnv_pkg::VAR_FNV1_64);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_mode();
    test_each_mode();
    test_partial_key_drop();
    test_back_pressure();
    test_random_keys(RANDOM_ITEMS);
    wait_idle();

    $display("Run covered %0d key beats and %0d checked hashes over all four modes,",
             beats_sent, hashes_seen);
    $display("with empty keys, idle beats, dropped partial keys and a long output hold-off.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d failures in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> fnv_key_hash_engine_top.f
src/fnv_pkg.sv
src/fnv_key_hash_engine_top.sv
verif/fnv_key_hash_engine_top_tb.sv
